/* rtl/core/assert_macros.svh */
// Assertion macros shared by the coefficient unpacker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define JC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define JC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JC_ASSERT(lbl, clk, rstn, prop, msg)
`define JC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/jcrlu_pkg.sv */
// Types, constants and helper functions of the coefficient unpacker.
`default_nettype none

package jcrlu_pkg;

  // Block geometry; the walk is written for an eight by eight block.
  localparam int BLOCK_SIDE = 8;
  localparam int BLOCK_AREA = BLOCK_SIDE * BLOCK_SIDE;
  localparam int SIDE_W     = $clog2(BLOCK_SIDE);
  localparam int POS_W      = $clog2(BLOCK_AREA);

  // Default number of DC predictors.
  localparam int CHANNEL_COUNT_DEF = 4;

  localparam int CHAN_W  = 2;
  localparam int NIB_W   = 4;
  localparam int EXTRA_W = 15;
  localparam int COEF_W  = 16;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ZEROS   = 2'd1,
    STATUS_NO_ROOM = 2'd2
  } status_t;

  // One decoded symbol.
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [NIB_W-1:0]   run;
    logic [NIB_W-1:0]   size;
    logic [EXTRA_W-1:0] extra_bits;
  } in_item_t;

  // One coefficient result.
  typedef struct packed {
    logic [POS_W-1:0]         index;
    logic signed [COEF_W-1:0] value;
    logic                     last;
    status_t                  status;
  } out_item_t;

  // Controls of the zigzag walk.
  typedef struct packed {
    logic advance;
    logic restart;
  } walk_ctl_t;

  // Status of the zigzag walk.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] index;
    logic             at_end;
  } walk_stat_t;

  // Controls of the DC predictor unit.
  typedef struct packed {
    logic start;
    logic commit;
  } dc_ctl_t;

  // JPEG sign extension of size magnitude bits.
  function automatic logic signed [COEF_W-1:0] extend_magnitude(
    input logic [NIB_W-1:0]   size,
    input logic [EXTRA_W-1:0] bits
  );
    logic [COEF_W-1:0] span;
    logic [COEF_W-1:0] top_bit;
    logic [COEF_W-1:0] masked;
    span    = (COEF_W'(1) << size) - COEF_W'(1);
    top_bit = span ^ (span >> 1);
    masked  = {1'b0, bits} & span;
    if ((masked & top_bit) != '0) begin
      extend_magnitude = masked;
    end else begin
      extend_magnitude = masked - span;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jpeg_coefficient_run_length_unpack.sv */
// Top level of the coefficient unpacker: symbol sequencer and result register.
//
// Usage:
//   The in_ channel takes one Huffman-decoded symbol per transaction
//   (channel, run, size, extra_bits); the out_ channel gives coefficient
//   results (natural index, value, last, status), both valid/ready.
//   At block position zero a symbol is the DC difference: the predictor of
//   its channel is read from a small RAM, added, saturated and written back,
//   giving one result. Later symbols give their zero run and then the
//   coefficient; end of block gives zeros up to the final position.
//   A run that does not fit gives one error result and restarts the block.
// Sequencing:
//   A symbol is taken in the idle state; its results then leave one per
//   cycle while the output slot is free. The single result sequencer handles
//   one symbol at a time. The first result is formed in the state after
//   acceptance and then held in the output register.
// Reset and stalls:
//   Reset restarts the walk at position zero; all predictors then read as zero.
//   While out_ready is low a valid result stays in its register and the sequencer waits;
//   a new symbol is taken once the previous one has issued all its results.
`default_nettype none

`include "assert_macros.svh"

module jpeg_coefficient_run_length_unpack #(
  parameter int CHANNEL_COUNT = jcrlu_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire jcrlu_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output jcrlu_pkg::out_item_t       out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DC   = 5'b00010,
    S_RUN  = 5'b00100,
    S_EOB  = 5'b01000,
    S_ERR  = 5'b10000
  } state_t;

  localparam int PW = jcrlu_pkg::POS_W;

  state_t                           state_r, state_nxt;
  jcrlu_pkg::in_item_t              item_r;
  logic [jcrlu_pkg::NIB_W-1:0]      zeros_r, zeros_nxt;
  jcrlu_pkg::status_t               err_r;
  jcrlu_pkg::out_item_t             out_r;
  logic                             out_valid_r;
  jcrlu_pkg::out_item_t             push_data;
  logic                             push;
  logic                             slot_free;
  logic                             accept;
  logic [PW:0]                      remaining;
  logic                             too_long;
  logic signed [jcrlu_pkg::COEF_W-1:0] coef;
  logic signed [jcrlu_pkg::COEF_W-1:0] dc_sum;
  jcrlu_pkg::walk_ctl_t             walk_ctl;
  jcrlu_pkg::walk_stat_t            walk_st;
  jcrlu_pkg::dc_ctl_t               dc_ctl;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Positions left in the block and the run-overflow test at acceptance.
  assign remaining = (PW + 1)'(jcrlu_pkg::BLOCK_AREA) - {1'b0, walk_st.pos};
  assign too_long  = ((PW + 1)'(in_data.run) >= remaining);

  assign coef = jcrlu_pkg::extend_magnitude(item_r.size, item_r.extra_bits);

  jcrlu_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (walk_ctl),
    .stat  (walk_st)
  );

  // The lookup address comes with the transaction; the difference is taken
  // from the held symbol when the sum is formed in the DC state that follows.
  jcrlu_dc #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dc_ctl),
    .channel (in_data.channel),
    .coef    (coef),
    .sum     (dc_sum)
  );

  // Result sequencer: after a symbol is taken, one result per cycle whenever the output slot is free.
  always_comb begin
    state_nxt        = state_r;
    zeros_nxt        = zeros_r;
    push             = 1'b0;
    push_data.index  = walk_st.index;
    push_data.value  = '0;
    push_data.last   = 1'b0;
    push_data.status = jcrlu_pkg::STATUS_OK;
    walk_ctl.advance = 1'b0;
    walk_ctl.restart = 1'b0;
    dc_ctl.start     = 1'b0;
    dc_ctl.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          zeros_nxt = in_data.run;
          if (walk_st.pos == '0) begin
            dc_ctl.start = 1'b1;
            state_nxt    = S_DC;
          end else if (in_data.run == '0 && in_data.size == '0) begin
            state_nxt = S_EOB;
          end else if (too_long) begin
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_DC: begin
        push_data.value = dc_sum;
        if (slot_free) begin
          push             = 1'b1;
          dc_ctl.commit    = 1'b1;
          walk_ctl.advance = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_RUN: begin
        if (zeros_r == '0) begin
          push_data.value = coef;
          push_data.last  = walk_st.at_end;
        end
        if (slot_free) begin
          push             = 1'b1;
          walk_ctl.advance = 1'b1;
          if (zeros_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            zeros_nxt = zeros_r - 1'b1;
          end
        end
      end
      S_EOB: begin
        push_data.last = walk_st.at_end;
        if (slot_free) begin
          push             = 1'b1;
          walk_ctl.advance = 1'b1;
          if (walk_st.at_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        push_data.index  = '0;
        push_data.last   = 1'b1;
        push_data.status = err_r;
        if (slot_free) begin
          push             = 1'b1;
          walk_ctl.restart = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= push || (out_valid_r && !out_ready);
    end
  end

  // Payload registers: the held symbol, error status, run counter and result slot.
  always_ff @(posedge clk) begin
    zeros_r <= zeros_nxt;
    if (accept) begin
      item_r <= in_data;
      err_r  <= ((PW + 1)'(in_data.run) > remaining) ? jcrlu_pkg::STATUS_ZEROS
                                                     : jcrlu_pkg::STATUS_NO_ROOM;
    end
    if (push) begin
      out_r <= push_data;
    end
  end

  // The DC lookup only runs at the start of a block.
  `JC_ASSERT(a_dc_at_start, clk, rst_n, (state_r == S_DC) |-> (walk_st.pos == '0), "DC symbol away from block start")
  // A result that closes a block leaves the walk at its start.
  `JC_ASSERT(a_last_restarts, clk, rst_n, (push && push_data.last) |=> (walk_st.pos == '0), "walk not restarted after last")
  // Error results always carry index zero and close the block.
  `JC_ASSERT(a_error_shape, clk, rst_n, (out_valid_r && out_r.status != jcrlu_pkg::STATUS_OK) |-> (out_r.last && out_r.index == '0), "malformed error result")

endmodule

`default_nettype wire

/* rtl/core/jcrlu_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module jcrlu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jcrlu_walk.sv */
// Zigzag walk over the block: position counter and row/column tracker.
`default_nettype none

`include "assert_macros.svh"

module jcrlu_walk (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire jcrlu_pkg::walk_ctl_t   ctl,
  output jcrlu_pkg::walk_stat_t       stat
);

  localparam logic [jcrlu_pkg::SIDE_W-1:0] SIDE_MAX = jcrlu_pkg::SIDE_W'(jcrlu_pkg::BLOCK_SIDE - 1);
  localparam logic [jcrlu_pkg::POS_W-1:0]  POS_MAX  = jcrlu_pkg::POS_W'(jcrlu_pkg::BLOCK_AREA - 1);

  logic [jcrlu_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [jcrlu_pkg::SIDE_W-1:0] row_r, row_nxt;
  logic [jcrlu_pkg::SIDE_W-1:0] col_r, col_nxt;

  // Status seen by the sequencer; the side is a power of two, so the
  // natural index is the row and column bits side by side.
  assign stat.pos    = pos_r;
  assign stat.index  = {row_r, col_r};
  assign stat.at_end = (pos_r == POS_MAX);

  // Next step along the zigzag; odd diagonals run down-left.
  always_comb begin
    pos_nxt = pos_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (ctl.restart || (ctl.advance && stat.at_end)) begin
      pos_nxt = '0;
      row_nxt = '0;
      col_nxt = '0;
    end else if (ctl.advance) begin
      pos_nxt = pos_r + 1'b1;
      if (row_r[0] ^ col_r[0]) begin
        if (row_r == SIDE_MAX) begin
          col_nxt = col_r + 1'b1;
        end else if (col_r == '0) begin
          row_nxt = row_r + 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
          col_nxt = col_r - 1'b1;
        end
      end else begin
        if (col_r == SIDE_MAX) begin
          row_nxt = row_r + 1'b1;
        end else if (row_r == '0) begin
          col_nxt = col_r + 1'b1;
        end else begin
          row_nxt = row_r - 1'b1;
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // The position counter and the row/column pair must describe one place.
  `JC_ASSERT(a_walk_origin, clk, rst_n, (pos_r == '0) |-> (row_r == '0 && col_r == '0), "walk origin mismatch")
  `JC_ASSERT(a_walk_corner, clk, rst_n, (pos_r == POS_MAX) |-> (row_r == SIDE_MAX && col_r == SIDE_MAX), "walk corner mismatch")

endmodule

`default_nettype wire

/* rtl/core/jcrlu_dc.sv */
// DC predictor unit: predictor memory, read, add with saturation, write back.
`default_nettype none

`include "assert_macros.svh"

module jcrlu_dc #(
  parameter int CHANNEL_COUNT = jcrlu_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire jcrlu_pkg::dc_ctl_t                         ctl,
  input  wire logic [jcrlu_pkg::CHAN_W-1:0]               channel,
  input  wire logic signed [jcrlu_pkg::COEF_W-1:0]        coef,
  output logic signed [jcrlu_pkg::COEF_W-1:0]             sum
);

  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int W  = jcrlu_pkg::COEF_W;

  logic [CHANNEL_COUNT-1:0] valid_r, valid_nxt;
  logic [AW-1:0]            addr_r;
  logic                     in_range_r;
  logic                     hit_r;
  logic                     in_range;
  logic [AW-1:0]            addr;
  logic [W-1:0]             rdata;
  logic signed [W-1:0]      pred;
  logic signed [W:0]        wide_sum;
  logic                     busy_r;

  // Channels at or above the predictor count predict from zero and store nothing.
  assign in_range = ({1'b0, channel} < (jcrlu_pkg::CHAN_W + 1)'(CHANNEL_COUNT));
  assign addr     = AW'(channel);

  jcrlu_ram #(
    .WIDTH (W),
    .DEPTH (CHANNEL_COUNT)
  ) u_pred_ram (
    .clk   (clk),
    .we    (ctl.commit && in_range_r),
    .waddr (addr_r),
    .wdata (sum),
    .re    (ctl.start && in_range),
    .raddr (addr),
    .rdata (rdata)
  );

  // A predictor never written since reset reads as zero.
  assign pred     = hit_r ? $signed(rdata) : '0;
  assign wide_sum = {pred[W-1], pred} + {coef[W-1], coef};

  // Saturate to the coefficient range.
  always_comb begin
    case (wide_sum[W:W-1])
      2'b01:   sum = {1'b0, {(W-1){1'b1}}};
      2'b10:   sum = {1'b1, {(W-1){1'b0}}};
      default: sum = wide_sum[W-1:0];
    endcase
  end

  // Valid bits mark predictors written since reset.
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.commit && in_range_r) begin
      valid_nxt[addr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (ctl.commit) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Lookup context held from the read until the write back.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      addr_r     <= addr;
      in_range_r <= in_range;
      hit_r      <= in_range && valid_r[addr];
    end
  end

  // A write back always closes a lookup, and lookups never overlap.
  `JC_ASSERT(a_commit_after_start, clk, rst_n, ctl.commit |-> busy_r, "predictor write without lookup")
  `JC_ASSERT(a_no_overlap, clk, rst_n, ctl.start |-> !busy_r, "predictor lookups overlap")

endmodule

`default_nettype wire
